### rtl/core/mbrh_pkg.sv
package mbrh_pkg;

  // Holding store geometry
  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned REG_AW    = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  // Response word counter: quantity never exceeds REG_COUNT <= 63
  localparam int unsigned IDX_W     = 6;

  // Protocol constants
  localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
  localparam logic [7:0] EXC_FLAG          = 8'h80;
  localparam logic [7:0] MBAP_BASE_LEN     = 8'd3;

  // Exception codes
  localparam logic [1:0] EXC_NONE             = 2'd0;
  localparam logic [1:0] EXC_ILLEGAL_FUNCTION = 2'd1;
  localparam logic [1:0] EXC_ILLEGAL_ADDRESS  = 2'd2;

  // Response item kinds
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  // Request modes
  localparam logic MODE_RX_BYTE    = 1'b0;
  localparam logic MODE_STORE_WRITE = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] transaction_id;
    logic [15:0] protocol_id;
    logic [7:0]  mbap_length;
    logic [7:0]  unit_id;
    logic [7:0]  function_code;
    logic [1:0]  exception_code;
    logic [6:0]  byte_count;
    logic [15:0] reg_word;
    logic        last;
  } rsp_t;

  // Controller -> datapath
  typedef struct packed {
    logic rx_take;    // request accepted this cycle
    logic load_hdr;   // load response header into output register
    logic issue_rd;   // read holding store at start + index
    logic load_word;  // load read word into output register
    logic clr_idx;    // restart word index
    logic inc_idx;    // advance word index
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic frame_done; // complete frame with full body seen this cycle
    logic hdr_last;   // header is the only item of the response
    logic word_last;  // current word is the final one
    logic out_free;   // output register can take an item
  } sts_t;

endpackage

### rtl/core/mbrh_if.sv
interface mbrh_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  rx_byte;
  logic [4:0]  store_index;
  logic [15:0] store_value;

  modport source (output valid, mode, rx_byte, store_index, store_value, input ready);
  modport sink   (input valid, mode, rx_byte, store_index, store_value, output ready);
endinterface

interface mbrh_rsp_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] transaction_id;
  logic [15:0] protocol_id;
  logic [7:0]  mbap_length;
  logic [7:0]  unit_id;
  logic [7:0]  function_code;
  logic [1:0]  exception_code;
  logic [6:0]  byte_count;
  logic [15:0] reg_word;
  logic        last;

  modport source (output valid, kind, transaction_id, protocol_id, mbap_length, unit_id,
                  function_code, exception_code, byte_count, reg_word, last,
                  input ready);
  modport sink   (input valid, kind, transaction_id, protocol_id, mbap_length, unit_id,
                  function_code, exception_code, byte_count, reg_word, last,
                  output ready);
endinterface

### rtl/core/mbrh_ram.sv
module mbrh_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/mbrh_dp.sv
module mbrh_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mbrh_pkg::cmd_t    cmd_i,
  output mbrh_pkg::sts_t    sts_o,
  input  logic              mode_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [4:0]        store_index_i,
  input  logic [15:0]       store_value_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output mbrh_pkg::rsp_t    out_o
);

  // Frame positions: header bytes, then body bytes, then "body used up"
  localparam logic [3:0] POS_TID_HI  = 4'd0;
  localparam logic [3:0] POS_TID_LO  = 4'd1;
  localparam logic [3:0] POS_PID_HI  = 4'd2;
  localparam logic [3:0] POS_PID_LO  = 4'd3;
  localparam logic [3:0] POS_LEN_HI  = 4'd4;
  localparam logic [3:0] POS_LEN_LO  = 4'd5;
  localparam logic [3:0] POS_UNIT    = 4'd6;
  localparam logic [3:0] POS_FUNC    = 4'd7;
  localparam logic [3:0] POS_START_H = 4'd8;
  localparam logic [3:0] POS_START_L = 4'd9;
  localparam logic [3:0] POS_QTY_HI  = 4'd10;
  localparam logic [3:0] POS_QTY_LO  = 4'd11;
  localparam logic [3:0] POS_SKIP    = 4'd12;

  logic [3:0]  pos_q, pos_d;
  logic [15:0] len_q, len_d;
  logic [15:0] tid_q, pid_q, start_q, qty_q;
  logic [7:0]  unit_q, func_q;
  logic [mbrh_pkg::IDX_W-1:0] idx_q;
  logic [mbrh_pkg::IDX_W-1:0] idx_inc;

  logic        take_byte;
  logic        frame_done;
  logic        store_we;
  logic [mbrh_pkg::REG_AW-1:0] store_waddr;
  logic [mbrh_pkg::REG_AW-1:0] rd_addr;
  logic [15:0] rd_sum;
  logic [15:0] ram_rdata;
  logic [mbrh_pkg::REG_COUNT-1:0] wr_seen_q;
  logic        rd_seen_q;

  logic        is_read;
  logic [16:0] span;
  logic        in_range;
  logic [6:0]  ok_count;
  mbrh_pkg::rsp_t hdr, word;

  logic           out_valid_q;
  mbrh_pkg::rsp_t out_q;

  assign take_byte = cmd_i.rx_take && (mode_i == mbrh_pkg::MODE_RX_BYTE);
  assign store_we  = cmd_i.rx_take && (mode_i == mbrh_pkg::MODE_STORE_WRITE) &&
                     ({1'b0, store_index_i} < 6'(mbrh_pkg::REG_COUNT));
  assign store_waddr = mbrh_pkg::REG_AW'(store_index_i);

  // Frame parser: next position and remaining body length
  always_comb begin
    pos_d = pos_q;
    len_d = len_q;
    frame_done = 1'b0;
    if (take_byte) begin
      if (pos_q < POS_UNIT) begin
        if (pos_q == POS_LEN_LO) begin
          len_d = {len_q[15:8], rx_byte_i};
          pos_d = ({len_q[15:8], rx_byte_i} == 16'd0) ? POS_TID_HI : POS_UNIT;
        end else begin
          if (pos_q == POS_LEN_HI) begin
            len_d = {rx_byte_i, 8'h00};
          end
          pos_d = pos_q + 4'd1;
        end
      end else begin
        if (pos_q < POS_SKIP) begin
          pos_d = pos_q + 4'd1;
        end
        if (len_q != 16'd0) begin
          len_d = len_q - 16'd1;
        end
        if (len_d == 16'd0) begin
          frame_done = (pos_d == POS_SKIP);
          pos_d = POS_TID_HI;
        end
      end
    end
  end

  assign sts_o.frame_done = frame_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_TID_HI;
      len_q <= 16'd0;
    end else begin
      pos_q <= pos_d;
      len_q <= len_d;
    end
  end

  // Capture header and body fields
  always_ff @(posedge clk_i) begin
    if (take_byte) begin
      case (pos_q)
        POS_TID_HI:  tid_q[15:8]   <= rx_byte_i;
        POS_TID_LO:  tid_q[7:0]    <= rx_byte_i;
        POS_PID_HI:  pid_q[15:8]   <= rx_byte_i;
        POS_PID_LO:  pid_q[7:0]    <= rx_byte_i;
        POS_UNIT:    unit_q        <= rx_byte_i;
        POS_FUNC:    func_q        <= rx_byte_i;
        POS_START_H: start_q[15:8] <= rx_byte_i;
        POS_START_L: start_q[7:0]  <= rx_byte_i;
        POS_QTY_HI:  qty_q[15:8]   <= rx_byte_i;
        POS_QTY_LO:  qty_q[7:0]    <= rx_byte_i;
        default: ;
      endcase
    end
  end

  // Holding store with per-entry written flags; unwritten entries read zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_seen_q <= '0;
    end else if (store_we) begin
      wr_seen_q[store_waddr] <= 1'b1;
    end
  end

  assign rd_sum  = start_q + {{(16-mbrh_pkg::IDX_W){1'b0}}, idx_q};
  assign rd_addr = rd_sum[mbrh_pkg::REG_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue_rd) begin
      rd_seen_q <= wr_seen_q[rd_addr];
    end
  end

  mbrh_ram #(
    .WIDTH (16),
    .DEPTH (mbrh_pkg::REG_COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (store_waddr),
    .wdata_i (store_value_i),
    .re_i    (cmd_i.issue_rd),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // Word index
  assign idx_inc = idx_q + mbrh_pkg::IDX_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.clr_idx) begin
      idx_q <= '0;
    end else if (cmd_i.inc_idx) begin
      idx_q <= idx_inc;
    end
  end

  // Response header
  assign is_read  = (func_q == mbrh_pkg::FUNC_READ_HOLDING);
  assign span     = {1'b0, start_q} + {1'b0, qty_q};
  assign in_range = (span <= 17'(mbrh_pkg::REG_COUNT));
  assign ok_count = {qty_q[5:0], 1'b0};

  always_comb begin
    hdr = '0;
    hdr.kind           = mbrh_pkg::KIND_HEADER;
    hdr.transaction_id = tid_q;
    hdr.protocol_id    = pid_q;
    hdr.unit_id        = unit_q;
    if (!is_read || !in_range) begin
      hdr.mbap_length    = mbrh_pkg::MBAP_BASE_LEN;
      hdr.function_code  = func_q | mbrh_pkg::EXC_FLAG;
      hdr.exception_code = is_read ? mbrh_pkg::EXC_ILLEGAL_ADDRESS
                                   : mbrh_pkg::EXC_ILLEGAL_FUNCTION;
      hdr.byte_count     = 7'd0;
      hdr.last           = 1'b1;
    end else begin
      hdr.mbap_length    = mbrh_pkg::MBAP_BASE_LEN + {1'b0, ok_count};
      hdr.function_code  = func_q;
      hdr.exception_code = mbrh_pkg::EXC_NONE;
      hdr.byte_count     = ok_count;
      hdr.last           = (qty_q == 16'd0);
    end
  end

  always_comb begin
    word = '0;
    word.kind     = mbrh_pkg::KIND_DATA;
    word.reg_word = rd_seen_q ? ram_rdata : 16'd0;
    word.last     = sts_o.word_last;
  end

  assign sts_o.hdr_last  = hdr.last;
  assign sts_o.word_last = ({{(16-mbrh_pkg::IDX_W){1'b0}}, idx_inc} == qty_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_hdr || cmd_i.load_word) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_hdr) begin
      out_q <= hdr;
    end else if (cmd_i.load_word) begin
      out_q <= word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

### rtl/core/mbrh_ctrl.sv
module mbrh_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mbrh_pkg::sts_t sts_i,
  output mbrh_pkg::cmd_t cmd_o
);

  localparam logic [1:0] ST_RECV = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_DATA = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_RECV);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_RECV: begin
        cmd_o.rx_take = in_valid_i;
        if (sts_i.frame_done) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts_i.out_free) begin
          cmd_o.load_hdr = 1'b1;
          cmd_o.clr_idx  = 1'b1;
          state_d = sts_i.hdr_last ? ST_RECV : ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.issue_rd = 1'b1;
        state_d = ST_DATA;
      end
      ST_DATA: begin
        if (sts_i.out_free) begin
          cmd_o.load_word = 1'b1;
          cmd_o.inc_idx   = 1'b1;
          state_d = sts_i.word_last ? ST_RECV : ST_READ;
        end
      end
      default: begin
        state_d = ST_RECV;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RECV;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/modbus_tcp_read_holding_responder_top.sv
// Modbus TCP read-holding-registers responder.
//
// Request channel (req_i): one request per cycle while ready is high. In
// byte mode a request carries the next byte of a Modbus TCP frame; in
// store-write mode it writes one holding register (indexes past the store
// are ignored) and produces no response.
// Response channel (rsp_o): a header item, then one data item per register
// word for a good read; exceptions give a header item alone. last marks the
// final item of each response.
// Throughput: frame bytes and store writes are taken at one per cycle.
// After the byte that completes a frame, requests are held off while the
// response is produced: the header is evaluated and loaded, then each
// register word is read from the store and then loaded into the output
// register, each load waiting until the output register is free.
// Header: the sequencer evaluates the completed frame, then registers the header.
// Reset: the store reads as all zeros, frame reception restarts at the
// MBAP header and the response register is emptied. No clearing pass.
// Receiver stall: the output register holds its item; the response
// sequencer waits, and request intake resumes after the last item is
// loaded even if that item still waits to be taken.
module modbus_tcp_read_holding_responder_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  mbrh_req_if.sink      req_i,
  mbrh_rsp_if.source    rsp_o
);

  mbrh_pkg::cmd_t cmd;
  mbrh_pkg::sts_t sts;
  mbrh_pkg::rsp_t rsp_item;
  logic           rsp_valid;

  // Sequence intake and response emission
  mbrh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Parse frames, hold the store and drive the output register
  mbrh_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .mode_i        (req_i.mode),
    .rx_byte_i     (req_i.rx_byte),
    .store_index_i (req_i.store_index),
    .store_value_i (req_i.store_value),
    .out_ready_i   (rsp_o.ready),
    .out_valid_o   (rsp_valid),
    .out_o         (rsp_item)
  );

  assign rsp_o.valid          = rsp_valid;
  assign rsp_o.kind           = rsp_item.kind;
  assign rsp_o.transaction_id = rsp_item.transaction_id;
  assign rsp_o.protocol_id    = rsp_item.protocol_id;
  assign rsp_o.mbap_length    = rsp_item.mbap_length;
  assign rsp_o.unit_id        = rsp_item.unit_id;
  assign rsp_o.function_code  = rsp_item.function_code;
  assign rsp_o.exception_code = rsp_item.exception_code;
  assign rsp_o.byte_count     = rsp_item.byte_count;
  assign rsp_o.reg_word       = rsp_item.reg_word;
  assign rsp_o.last           = rsp_item.last;

endmodule

### test/tb_modbus_tcp_read_holding_responder_top.sv
module tb_modbus_tcp_read_holding_responder_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Quiet-cycle bounds: the longest legal silence is the forced receiver
  // stall plus a long random gap, so both limits sit far above that.
  localparam int STALL_CYCLES   = 150;
  localparam int DRAIN_LIMIT    = 1500;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 20;

  typedef logic [7:0] octet_q_t[$];

  // Kinds of request sequence that the random traffic mixes
  typedef enum int {
    FR_GOOD_READ,
    FR_ZERO_QTY,
    FR_BAD_ADDRESS,
    FR_BAD_FUNCTION,
    FR_SHORT,
    FR_TRAILING,
    FR_INTERLEAVED_WRITE,
    FR_WRITE_BURST,
    FR_GARBLED,
    FR_KIND_COUNT
  } frame_kind_e;

  logic clk_i;
  logic rst_ni;

  mbrh_req_if req_if ();
  mbrh_rsp_if rsp_if ();

  modbus_tcp_read_holding_responder_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow of the responder: holding store plus frame reception state
  logic [15:0] shadow_store [mbrh_pkg::REG_COUNT];
  int unsigned rx_pos;
  logic [15:0] body_left;
  logic [15:0] cur_tid;
  logic [15:0] cur_pid;
  logic [7:0]  cur_unit;
  logic [7:0]  cur_func;
  logic [15:0] cur_start;
  logic [15:0] cur_qty;

  // Response items owed by the block, oldest first
  mbrh_pkg::rsp_t owed_items[$];

  // Traffic shaping, set by the test sequence
  int src_idle_pct;
  int snk_idle_pct;
  int stall_req_cnt;
  int stall_done_cnt;

  // Bookkeeping
  int n_sent;
  int n_writes;
  int n_dropped;
  int n_results;
  int n_headers;
  int n_exceptions;
  int n_mismatches;
  int quiet_cycles;

  mbrh_pkg::rsp_t got_item;
  mbrh_pkg::rsp_t want_item;

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Error reporting and field comparison
  // ---------------------------------------------------------------------------

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string msg);
    n_mismatches++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic compare_field(input string name, input logic [15:0] got_v,
                               input logic [15:0] want_v);
    if (got_v !== want_v) begin
      report_mismatch($sformatf("item %0d field %s: got 0x%h, expected 0x%h",
                                n_results, name, got_v, want_v));
    end
  endtask

  // Append one item to the owed list
  function automatic void owe_item(input mbrh_pkg::rsp_t item);
    owed_items = {owed_items, item};
  endfunction

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Advance the shadow by one accepted request and queue whatever response
  // items it triggers.
  function automatic void predict_response(input logic mode, input logic [7:0] rx_b,
                                           input logic [4:0] idx,
                                           input logic [15:0] val);
    mbrh_pkg::rsp_t hdr;
    mbrh_pkg::rsp_t word;
    logic full_body;
    int   i;

    // Store writes touch only the store, never the frame state
    if (mode == mbrh_pkg::MODE_STORE_WRITE) begin
      if (idx < mbrh_pkg::REG_COUNT) shadow_store[idx] = val;
      n_writes++;
      return;
    end

    // MBAP header: transaction, protocol, length, high byte first
    if (rx_pos < 6) begin
      case (rx_pos)
        0: cur_tid = {rx_b, 8'h00};
        1: cur_tid[7:0] = rx_b;
        2: cur_pid = {rx_b, 8'h00};
        3: cur_pid[7:0] = rx_b;
        4: body_left = {rx_b, 8'h00};
        default: body_left[7:0] = rx_b;
      endcase
      if (rx_pos == 5) begin
        // An empty body ends the frame right here with no answer
        if (body_left == 16'd0) begin
          rx_pos = 0;
          n_dropped++;
        end else begin
          rx_pos = 6;
        end
      end else begin
        rx_pos++;
      end
      return;
    end

    // Body: only the first six bytes matter, the rest are skipped
    case (rx_pos - 6)
      0: cur_unit = rx_b;
      1: cur_func = rx_b;
      2: cur_start = {rx_b, 8'h00};
      3: cur_start[7:0] = rx_b;
      4: cur_qty = {rx_b, 8'h00};
      5: cur_qty[7:0] = rx_b;
      default: ;
    endcase
    if (rx_pos < 12) rx_pos++;
    if (body_left != 16'd0) body_left--;
    if (body_left != 16'd0) return;

    full_body = (rx_pos == 12);
    rx_pos = 0;
    if (!full_body) begin
      n_dropped++;
      return;
    end

    hdr = '0;
    hdr.kind           = mbrh_pkg::KIND_HEADER;
    hdr.transaction_id = cur_tid;
    hdr.protocol_id    = cur_pid;
    hdr.unit_id        = cur_unit;

    if (cur_func != mbrh_pkg::FUNC_READ_HOLDING) begin
      // The flag goes in even when the request already carries it
      hdr.mbap_length    = mbrh_pkg::MBAP_BASE_LEN;
      hdr.function_code  = cur_func | mbrh_pkg::EXC_FLAG;
      hdr.exception_code = mbrh_pkg::EXC_ILLEGAL_FUNCTION;
      hdr.last           = 1'b1;
      owe_item(hdr);
      return;
    end

    if (int'(cur_start) + int'(cur_qty) > mbrh_pkg::REG_COUNT) begin
      hdr.mbap_length    = mbrh_pkg::MBAP_BASE_LEN;
      hdr.function_code  = cur_func | mbrh_pkg::EXC_FLAG;
      hdr.exception_code = mbrh_pkg::EXC_ILLEGAL_ADDRESS;
      hdr.last           = 1'b1;
      owe_item(hdr);
      return;
    end

    hdr.mbap_length    = mbrh_pkg::MBAP_BASE_LEN + 8'(2 * cur_qty);
    hdr.function_code  = cur_func;
    hdr.exception_code = mbrh_pkg::EXC_NONE;
    hdr.byte_count     = 7'(2 * cur_qty);
    hdr.last           = (cur_qty == 16'd0);
    owe_item(hdr);

    for (i = 0; i < int'(cur_qty); i++) begin
      word          = '0;
      word.kind     = mbrh_pkg::KIND_DATA;
      word.reg_word = shadow_store[mbrh_pkg::REG_AW'(int'(cur_start) + i)];
      word.last     = (i + 1 == int'(cur_qty));
      owe_item(word);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offer one request, idling first at the current rate, and hold it until
  // taken. valid stays high on return so that back-to-back requests never
  // lower and raise it within one step.
  task automatic send_request(input logic mode, input logic [7:0] rx_b,
                              input logic [4:0] idx, input logic [15:0] val);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.mode        <= mode;
    req_if.rx_byte     <= rx_b;
    req_if.store_index <= idx;
    req_if.store_value <= val;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    n_sent++;
    predict_response(mode, rx_b, idx, val);
  endtask

  // Frame byte: the store fields are don't-care, so fill them with noise
  task automatic send_byte(input logic [7:0] rx_b);
    send_request(mbrh_pkg::MODE_RX_BYTE, rx_b, 5'($urandom), 16'($urandom));
  endtask

  task automatic send_store_write(input logic [4:0] idx, input logic [15:0] val);
    send_request(mbrh_pkg::MODE_STORE_WRITE, 8'($urandom), idx, val);
  endtask

  // Random write, leaning on the value extremes now and then
  task automatic send_random_write();
    logic [15:0] val;
    case ($urandom_range(0, 7))
      0:       val = 16'h0000;
      1:       val = 16'hFFFF;
      default: val = 16'($urandom);
    endcase
    send_store_write(5'($urandom_range(0, mbrh_pkg::REG_COUNT - 1)), val);
  endtask

  // Send MBAP header and body; write_at >= 0 slips a store write in ahead of
  // that byte position of the frame.
  task automatic send_frame(input logic [15:0] tid, input logic [15:0] pid,
                            input logic [15:0] len, input octet_q_t body,
                            input int write_at);
    octet_q_t frame;
    int       i;
    frame = '{tid[15:8], tid[7:0], pid[15:8], pid[7:0], len[15:8], len[7:0]};
    frame = {frame, body};
    for (i = 0; i < frame.size(); i++) begin
      if (i == write_at) send_random_write();
      send_byte(frame[i]);
    end
  endtask

  function automatic octet_q_t read_body(input logic [7:0] unit, input logic [7:0] func,
                                         input logic [15:0] start,
                                         input logic [15:0] qty);
    octet_q_t body;
    body = '{unit, func, start[15:8], start[7:0], qty[15:8], qty[7:0]};
    return body;
  endfunction

  function automatic frame_kind_e pick_frame_kind();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return FR_GOOD_READ;
    if (roll < 42) return FR_ZERO_QTY;
    if (roll < 52) return FR_BAD_ADDRESS;
    if (roll < 61) return FR_BAD_FUNCTION;
    if (roll < 68) return FR_SHORT;
    if (roll < 76) return FR_TRAILING;
    if (roll < 84) return FR_INTERLEAVED_WRITE;
    if (roll < 93) return FR_WRITE_BURST;
    return FR_GARBLED;
  endfunction

  // Build and send one sequence of the given kind with random content.
  task automatic send_random_frame(input frame_kind_e kind_sel);
    logic [15:0] tid;
    logic [15:0] pid;
    logic [15:0] start;
    logic [15:0] qty;
    logic [7:0]  unit;
    logic [7:0]  func;
    octet_q_t    body;
    int          room;
    int          write_at;

    tid      = 16'($urandom);
    pid      = 16'($urandom);
    unit     = 8'($urandom);
    func     = mbrh_pkg::FUNC_READ_HOLDING;
    start    = 16'($urandom_range(0, mbrh_pkg::REG_COUNT - 1));
    room     = mbrh_pkg::REG_COUNT - int'(start);
    // Keep most reads short; now and then let one run up to the end of the store
    if ($urandom_range(0, 3) == 0) qty = 16'($urandom_range(1, room));
    else qty = 16'($urandom_range(1, (room < 4) ? room : 4));
    write_at = -1;

    case (kind_sel)
      FR_ZERO_QTY: begin
        start = 16'($urandom_range(0, mbrh_pkg::REG_COUNT));
        qty   = 16'd0;
      end
      FR_BAD_ADDRESS: begin
        case ($urandom_range(0, 2))
          // just past the end of the store
          0: begin
            start = 16'($urandom_range(1, mbrh_pkg::REG_COUNT));
            qty   = 16'(mbrh_pkg::REG_COUNT + 1 - int'(start) + $urandom_range(0, 2));
          end
          1: begin
            start = 16'($urandom);
            qty   = 16'($urandom);
            if (int'(start) + int'(qty) <= mbrh_pkg::REG_COUNT) start = 16'hFFFF;
          end
          default: begin
            start = 16'h0000;
            qty   = 16'hFFFF;
          end
        endcase
      end
      FR_BAD_FUNCTION: begin
        func = 8'($urandom);
        // A read code with the flag already set must still be refused
        if (func == mbrh_pkg::FUNC_READ_HOLDING || $urandom_range(0, 4) == 0)
          func = mbrh_pkg::FUNC_READ_HOLDING | mbrh_pkg::EXC_FLAG;
        if ($urandom_range(0, 1) == 0) begin
          start = 16'($urandom);
          qty   = 16'($urandom);
        end
      end
      default: ;
    endcase

    body = read_body(unit, func, start, qty);

    case (kind_sel)
      FR_SHORT: begin
        body = {};
        repeat ($urandom_range(0, 5)) body = {body, 8'($urandom)};
      end
      FR_TRAILING: begin
        repeat ($urandom_range(1, 6)) body = {body, 8'($urandom)};
      end
      FR_INTERLEAVED_WRITE: write_at = $urandom_range(0, 11);
      FR_GARBLED: begin
        body = {};
        repeat ($urandom_range(6, 9)) body = {body, 8'($urandom)};
      end
      default: ;
    endcase

    if (kind_sel == FR_WRITE_BURST) begin
      repeat ($urandom_range(1, 4)) send_random_write();
    end else begin
      send_frame(tid, pid, 16'(body.size()), body, write_at);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Write the corner indexes and value extremes before anything reads them.
  task automatic test_store_extremes();
    send_store_write(5'd0, 16'hFFFF);
    send_store_write(5'(mbrh_pkg::REG_COUNT - 1), 16'h8001);
    send_store_write(5'd1, 16'h0000);
  endtask

  // Largest answer the store allows: every register in one response.
  task automatic test_full_store_read();
    send_frame(16'hFFFF, 16'h0000, 16'd6,
               read_body(8'hFF, mbrh_pkg::FUNC_READ_HOLDING, 16'h0000,
                         16'(mbrh_pkg::REG_COUNT)), -1);
  endtask

  // A zero body length drops the frame right after the MBAP header.
  task automatic test_empty_body();
    octet_q_t none;
    none = {};
    send_frame(16'h0000, 16'hFFFF, 16'd0, none, -1);
  endtask

  // Function already carrying the flag, with address fields at their top.
  task automatic test_flagged_function();
    send_frame(16'h1234, 16'h0000, 16'd6,
               read_body(8'h00, mbrh_pkg::FUNC_READ_HOLDING | mbrh_pkg::EXC_FLAG,
                         16'hFFFF, 16'hFFFF), -1);
  endtask

  // Mostly well-formed frames with random content, with drops, exceptions,
  // trailing bytes, interleaved writes and garbage mixed in. Optionally walk
  // through every kind once first.
  task automatic test_random_traffic(input int target, input bit each_kind_first);
    int base;
    int k;
    base = n_sent;
    if (each_kind_first) begin
      for (k = 0; k < FR_KIND_COUNT; k++) send_random_frame(frame_kind_e'(k));
    end
    while (n_sent - base < target) send_random_frame(pick_frame_kind());
  endtask

  // Hold the receiver off for a long stretch while frames keep coming, so
  // the output register fills and the block stalls request intake.
  task automatic test_backpressure();
    stall_req_cnt++;
    send_frame(16'($urandom), 16'($urandom), 16'd6,
               read_body(8'($urandom), mbrh_pkg::FUNC_READ_HOLDING, 16'h0000,
                         16'(mbrh_pkg::REG_COUNT)), -1);
    send_random_frame(FR_GOOD_READ);
    send_random_frame(FR_BAD_FUNCTION);
    send_random_frame(FR_WRITE_BURST);
  endtask

  // ---------------------------------------------------------------------------
  // Response side
  // ---------------------------------------------------------------------------

  // Receiver: random ready at the current idle rate, or a counted hold-off
  // whenever the test asks for one.
  initial begin
    int hold;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_done_cnt != stall_req_cnt) begin
        for (hold = 0; hold < STALL_CYCLES; hold++) begin
          rsp_if.ready <= 1'b0;
          @(posedge clk_i);
        end
        stall_done_cnt++;
      end
      rsp_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Compare each taken response item with the oldest one owed.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got_item.kind           = rsp_if.kind;
      got_item.transaction_id = rsp_if.transaction_id;
      got_item.protocol_id    = rsp_if.protocol_id;
      got_item.mbap_length    = rsp_if.mbap_length;
      got_item.unit_id        = rsp_if.unit_id;
      got_item.function_code  = rsp_if.function_code;
      got_item.exception_code = rsp_if.exception_code;
      got_item.byte_count     = rsp_if.byte_count;
      got_item.reg_word       = rsp_if.reg_word;
      got_item.last           = rsp_if.last;
      n_results++;
      if (got_item.kind == mbrh_pkg::KIND_HEADER) n_headers++;
      if (got_item.kind == mbrh_pkg::KIND_HEADER &&
          got_item.exception_code != mbrh_pkg::EXC_NONE)
        n_exceptions++;
      if (owed_items.size() == 0) begin
        report_mismatch($sformatf("item %0d arrived with nothing owed", n_results));
      end else begin
        want_item = owed_items.pop_front();
        compare_field("kind", 16'(got_item.kind), 16'(want_item.kind));
        compare_field("transaction_id", got_item.transaction_id,
                      want_item.transaction_id);
        compare_field("protocol_id", got_item.protocol_id, want_item.protocol_id);
        compare_field("mbap_length", 16'(got_item.mbap_length),
                      16'(want_item.mbap_length));
        compare_field("unit_id", 16'(got_item.unit_id), 16'(want_item.unit_id));
        compare_field("function_code", 16'(got_item.function_code),
                      16'(want_item.function_code));
        compare_field("exception_code", 16'(got_item.exception_code),
                      16'(want_item.exception_code));
        compare_field("byte_count", 16'(got_item.byte_count),
                      16'(want_item.byte_count));
        compare_field("reg_word", got_item.reg_word, want_item.reg_word);
        compare_field("last", 16'(got_item.last), 16'(want_item.last));
      end
    end
  end

  // Watchdog: count cycles with no handshake on either channel and give up
  // when the count runs past anything a correct block could produce.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d items still owed",
               quiet_cycles, owed_items.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    // Drive every input to a known value and hold reset
    rst_ni             <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.mode        <= mbrh_pkg::MODE_RX_BYTE;
    req_if.rx_byte     <= 8'h00;
    req_if.store_index <= 5'd0;
    req_if.store_value <= 16'h0000;

    // Shadow starts from the reset state: empty store, awaiting a header
    foreach (shadow_store[j]) shadow_store[j] = 16'h0000;
    rx_pos         = 0;
    body_left      = 16'd0;
    cur_tid        = 16'd0;
    cur_pid        = 16'd0;
    cur_unit       = 8'd0;
    cur_func       = 8'd0;
    cur_start      = 16'd0;
    cur_qty        = 16'd0;
    src_idle_pct   = 0;
    snk_idle_pct   = 0;
    stall_req_cnt  = 0;
    stall_done_cnt = 0;
    n_sent         = 0;
    n_writes       = 0;
    n_dropped      = 0;
    n_results      = 0;
    n_headers      = 0;
    n_exceptions   = 0;
    n_mismatches   = 0;
    quiet_cycles   = 0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners at full rate
    test_store_extremes();
    test_full_store_read();
    test_empty_body();
    test_flagged_function();

    // Busy sender, sparse receiver
    src_idle_pct = 9;
    snk_idle_pct = 68;
    test_random_traffic(75, 1'b1);

    // Fill the block up behind a stalled receiver
    src_idle_pct = 0;
    test_backpressure();

    // Sparse sender, busy receiver
    src_idle_pct = 68;
    snk_idle_pct = 9;
    test_random_traffic(75, 1'b0);

    // Full rate on both sides
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_traffic(75, 1'b0);

    // Drop valid, drain what is owed, then let the pipeline settle
    req_if.valid <= 1'b0;
    while (owed_items.size() != 0 && quiet_cycles < DRAIN_LIMIT) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (owed_items.size() != 0) begin
      report_mismatch($sformatf("%0d response items never arrived", owed_items.size()));
    end

    $display("Summary: %0d requests (%0d store writes, %0d frames dropped) sent",
             n_sent, n_writes, n_dropped);
    $display("Summary: %0d response items, %0d responses, %0d exceptions, %0d mismatches",
             n_results, n_headers, n_exceptions, n_mismatches);
    if (n_mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
